### hw/rtl/cmrf_pkg.sv
// Shared constants, types and codes of the convex minimum search block.
package cmrf_pkg;

    localparam int DEPTH       = 1024;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_STEPS   = 100;
    localparam int STEP_W      = 7;
    localparam int POS_W       = ADDR_W + FRAC_BITS;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int DEN_W       = DIFF_W + 1;
    localparam int PROD_W      = DIFF_W + POS_W;
    localparam int TOL_W       = 16 + FRAC_BITS;
    localparam int CMP_W       = POS_W + TOL_W;
    localparam int DIVC_W      = $clog2(POS_W + 1);
    localparam int CFG_W       = 16;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_FEW    = 3'd1,
        ST_SKIP_END   = 3'd2,
        ST_NO_BRACKET = 3'd3,
        ST_STEP_LIMIT = 3'd4
    } status_t;

    typedef enum logic {
        CFG_SKIP_RISING = 1'b0,
        CFG_TOLERANCE   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_SKIP,
        SEL_LOW,
        SEL_HIGH,
        SEL_EST
    } idx_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_LOW
    } idx_op_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [9:0] min_index;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic     ld_wr;
        logic     chk_init;
        logic     skip_inc;
        logic     setup;
        idx_sel_t fsel;
        logic     fphase;
        logic     cap_ya;
        logic     cap_d;
        logic     mul;
        logic     div_init;
        logic     div_step;
        logic     make_x;
        logic     update;
        idx_op_t  idx_op;
    } cmd_t;

    typedef struct packed {
        logic n_small;
        logic skip_en;
        logic skip_off;
        logic d_nonneg;
        logic same_sign;
        logic both_zero;
        logic div_last;
        logic conv_done;
        logic limit_hit;
    } stat_t;

endpackage

### hw/rtl/cmrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/cmrf_ctrl.sv
// Controller state machine sequencing loading, skipping and the regula falsi steps.
module cmrf_ctrl import cmrf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last,
    input  stat_t   stat,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output status_t status
);

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_SKCHK, S_SKEV, S_SETUP, S_F0, S_F1, S_F2,
        S_EVAL, S_MUL, S_DIVI, S_DIV, S_MKX, S_UPD
    } state_t;

    state_t   state_reg, state_next;
    idx_sel_t tgt_reg, tgt_next;
    logic     done_reg, done_next;
    status_t  status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        tgt_next    = tgt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '0;
        cmd.fsel    = tgt_reg;
        cmd.idx_op  = IDX_HOLD;
        unique case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    cmd.ld_wr = 1'b1;
                    if (last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.chk_init = 1'b1;
                if (stat.n_small)
                begin
                    cmd.idx_op  = IDX_ZERO;
                    done_next   = 1'b1;
                    status_next = ST_TOO_FEW;
                    state_next  = S_LOAD;
                end
                else if (stat.skip_en)
                begin
                    state_next = S_SKCHK;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SKCHK:
            begin
                if (stat.skip_off)
                begin
                    cmd.idx_op  = IDX_ZERO;
                    done_next   = 1'b1;
                    status_next = ST_SKIP_END;
                    state_next  = S_LOAD;
                end
                else
                begin
                    tgt_next   = SEL_SKIP;
                    state_next = S_F0;
                end
            end
            S_SKEV:
            begin
                if (stat.d_nonneg)
                begin
                    cmd.skip_inc = 1'b1;
                    state_next   = S_SKCHK;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                tgt_next   = SEL_LOW;
                state_next = S_F0;
            end
            S_F0:
            begin
                state_next = S_F1;
            end
            S_F1:
            begin
                cmd.fphase = 1'b1;
                cmd.cap_ya = 1'b1;
                state_next = S_F2;
            end
            S_F2:
            begin
                cmd.cap_d = 1'b1;
                unique case (tgt_reg)
                    SEL_SKIP: state_next = S_SKEV;
                    SEL_LOW:
                    begin
                        tgt_next   = SEL_HIGH;
                        state_next = S_F0;
                    end
                    SEL_HIGH: state_next = S_EVAL;
                    SEL_EST:  state_next = S_UPD;
                    default:  state_next = S_LOAD;
                endcase
            end
            S_EVAL:
            begin
                if (stat.same_sign)
                begin
                    cmd.idx_op  = IDX_ZERO;
                    done_next   = 1'b1;
                    status_next = ST_NO_BRACKET;
                    state_next  = S_LOAD;
                end
                else if (stat.both_zero)
                begin
                    cmd.idx_op  = IDX_LOW;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_LOAD;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_MKX;
                end
            end
            S_MKX:
            begin
                cmd.make_x = 1'b1;
                tgt_next   = SEL_EST;
                state_next = S_F0;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                if (stat.conv_done)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_LOAD;
                end
                else if (stat.limit_hit)
                begin
                    done_next   = 1'b1;
                    status_next = ST_STEP_LIMIT;
                    state_next  = S_LOAD;
                end
                else
                begin
                    tgt_next   = SEL_LOW;
                    state_next = S_F0;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            tgt_reg    <= SEL_SKIP;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            tgt_reg    <= tgt_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_LOAD);
    assign done   = done_reg;
    assign status = status_reg;

endmodule

### hw/rtl/cmrf_dp.sv
// Datapath: sample store, difference fetch, multiplier, divider and position registers.
module cmrf_dp import cmrf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic signed [31:0] sample,
    input  logic              last,
    input  logic              cfg_we,
    input  cfg_idx_t          cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output stat_t             stat,
    output logic [ADDR_W-1:0] min_index
);

    logic                     skip_reg;
    logic [15:0]              tol_cfg_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [ADDR_W-1:0]        hi_reg;
    logic [CNT_W-1:0]         lo_cnt_reg;
    logic [POS_W-1:0]         low_reg, high_reg, x_reg, prev_reg;
    logic                     prev_valid_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [SAMPLE_BITS-1:0] ya_reg;
    logic signed [DIFF_W-1:0] dlo_reg, dhi_reg, dx_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [POS_W-1:0]         dvd_reg;
    logic [POS_W-1:0]         q_reg;
    logic [DIVC_W-1:0]        dcnt_reg;
    logic [ADDR_W-1:0]        idx_reg;

    logic                     wr_ok;
    logic [CNT_W-1:0]         base;
    logic [ADDR_W-1:0]        adj;
    logic [ADDR_W-1:0]        rd_addr;
    logic [SAMPLE_BITS-1:0]   rd_data;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag_lo, mag_hi;
    logic [POS_W-1:0]         span;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           rem_sub;
    logic [POS_W-1:0]         err;
    logic [TOL_W-1:0]         tol_full;
    logic [TOL_W-1:0]         tol;
    logic                     low_sel;

    assign wr_ok = (count_reg < CNT_W'(DEPTH));

    cmrf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_store (
        .clk     (clk),
        .wr_en   (cmd.ld_wr && wr_ok),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (sample[SAMPLE_BITS-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (cmd.fsel)
            SEL_SKIP: base = lo_cnt_reg;
            SEL_LOW:  base = {1'b0, low_reg[POS_W-1:FRAC_BITS]};
            SEL_HIGH: base = {1'b0, high_reg[POS_W-1:FRAC_BITS]};
            default:  base = {1'b0, x_reg[POS_W-1:FRAC_BITS]};
        endcase
        if (base >= {1'b0, hi_reg})
        begin
            adj = hi_reg - ADDR_W'(1);
        end
        else
        begin
            adj = base[ADDR_W-1:0];
        end
        rd_addr = cmd.fphase ? adj + ADDR_W'(1) : adj;
    end

    assign diff   = DIFF_W'($signed(rd_data)) - DIFF_W'(ya_reg);
    assign mag_lo = dlo_reg[DIFF_W-1] ? DIFF_W'(-dlo_reg) : DIFF_W'(dlo_reg);
    assign mag_hi = dhi_reg[DIFF_W-1] ? DIFF_W'(-dhi_reg) : DIFF_W'(dhi_reg);
    assign span   = (high_reg >= low_reg) ? high_reg - low_reg : '0;
    assign rem_sh  = {rem_reg, dvd_reg[POS_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign err      = (x_reg >= prev_reg) ? x_reg - prev_reg : prev_reg - x_reg;
    assign tol_full = {tol_cfg_reg, {FRAC_BITS{1'b0}}};
    assign tol      = tol_full >> 16;
    assign low_sel  = (dx_reg == '0) || (dlo_reg == '0) ||
                      (dx_reg[DIFF_W-1] == dlo_reg[DIFF_W-1]);

    assign stat.n_small   = (n_reg < CNT_W'(3));
    assign stat.skip_en   = skip_reg;
    assign stat.skip_off  = (lo_cnt_reg > {1'b0, hi_reg});
    assign stat.d_nonneg  = !dx_reg[DIFF_W-1];
    assign stat.same_sign = (dlo_reg != '0) && (dhi_reg != '0) &&
                            (dlo_reg[DIFF_W-1] == dhi_reg[DIFF_W-1]);
    assign stat.both_zero = (dlo_reg == dhi_reg);
    assign stat.div_last  = (dcnt_reg == DIVC_W'(POS_W - 1));
    assign stat.conv_done = prev_valid_reg && (CMP_W'(err) < CMP_W'(tol));
    assign stat.limit_hit = ((STEP_W + 1)'(step_reg) + (STEP_W + 1)'(1)) >=
                            (STEP_W + 1)'(MAX_STEPS);

    assign min_index = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg       <= 1'b0;
            tol_cfg_reg    <= 16'd6554;
            count_reg      <= '0;
            n_reg          <= '0;
            prev_valid_reg <= 1'b0;
            step_reg       <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SKIP_RISING: skip_reg    <= cfg_data[0];
                    CFG_TOLERANCE:   tol_cfg_reg <= cfg_data[15:0];
                    default:         skip_reg    <= skip_reg;
                endcase
            end
            if (cmd.ld_wr)
            begin
                if (last)
                begin
                    count_reg <= '0;
                    n_reg     <= count_reg + CNT_W'(wr_ok);
                end
                else if (wr_ok)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.setup)
            begin
                low_reg        <= POS_W'(lo_cnt_reg) << FRAC_BITS;
                high_reg       <= POS_W'(hi_reg) << FRAC_BITS;
                prev_valid_reg <= 1'b0;
                step_reg       <= '0;
            end
            if (cmd.update)
            begin
                if (low_sel)
                begin
                    low_reg <= x_reg;
                end
                else
                begin
                    high_reg <= x_reg;
                end
                step_reg       <= step_reg + STEP_W'(1);
                prev_valid_reg <= 1'b1;
                idx_reg        <= x_reg[POS_W-1:FRAC_BITS];
            end
            case (cmd.idx_op)
                IDX_ZERO: idx_reg <= '0;
                IDX_LOW:  idx_reg <= low_reg[POS_W-1:FRAC_BITS];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chk_init)
        begin
            hi_reg     <= ADDR_W'(n_reg - CNT_W'(1));
            lo_cnt_reg <= '0;
        end
        if (cmd.skip_inc)
        begin
            lo_cnt_reg <= lo_cnt_reg + CNT_W'(1);
        end
        if (cmd.cap_ya)
        begin
            ya_reg <= $signed(rd_data);
        end
        if (cmd.cap_d)
        begin
            case (cmd.fsel)
                SEL_LOW:  dlo_reg <= diff;
                SEL_HIGH: dhi_reg <= diff;
                default:  dx_reg  <= diff;
            endcase
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mag_lo) * PROD_W'(span);
            den_reg  <= DEN_W'(mag_lo) + DEN_W'(mag_hi);
        end
        if (cmd.div_init)
        begin
            rem_reg  <= DEN_W'(prod_reg[PROD_W-1:POS_W]);
            dvd_reg  <= prod_reg[POS_W-1:0];
            q_reg    <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (!rem_sub[DEN_W])
            begin
                rem_reg <= rem_sub[DEN_W-1:0];
                q_reg   <= {q_reg[POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DEN_W-1:0];
                q_reg   <= {q_reg[POS_W-2:0], 1'b0};
            end
            dvd_reg  <= {dvd_reg[POS_W-2:0], 1'b0};
            dcnt_reg <= dcnt_reg + DIVC_W'(1);
        end
        if (cmd.make_x)
        begin
            x_reg <= low_reg + q_reg;
        end
        if (cmd.update)
        begin
            prev_reg <= x_reg;
        end
    end

endmodule

### hw/rtl/convex_min_regula_falsi_search.sv
// Top level of the convex curve minimum search by regula falsi on the first difference.
// Loading accepts one sample transfer per cycle; start is taken whenever busy is low.
// After the last sample, a search runs at most 100 regula falsi steps, preceded by one
// difference test per index passed while skipping; each step uses sample reads and a serial divider.
// The result appears on done for exactly one cycle; the receiver cannot stall it.
// Reset is asynchronous and active low; it clears control state but not the sample store.
module convex_min_regula_falsi_search import cmrf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t              cmd;
    stat_t             stat;
    status_t           status;
    logic [ADDR_W-1:0] min_index;

    cmrf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (item.last),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    cmrf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (item.sample),
        .last      (item.last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .min_index (min_index)
    );

    assign result.min_index = 10'(min_index);
    assign result.status    = status;

endmodule

### hw/rtl/cmrf_checker.sv
// Port-level checker for the minimum search block, with its bind statement.
module cmrf_checker import cmrf_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    done,
    input result_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("Result shown while the block is busy.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("Two results in consecutive cycles.");

    a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last) |=> !busy)
        else $error("Block became busy after a non-final sample transfer.");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last) |=> (busy && !done))
        else $error("Final sample transfer did not start a search.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= 3'd4))
        else $error("Result carries an undefined status code.");

endmodule

bind convex_min_regula_falsi_search cmrf_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

### tb/sv/tb.sv
// Self-checking testbench for the convex curve minimum search block.
`timescale 1ns / 1ps

module tb;
    import cmrf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20000000;
    localparam int          SETTLE      = 50;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             done;
    result_t          result;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    longint           curve_store [DEPTH];
    int unsigned      stored_count;
    bit               skip_rising_cfg;
    bit [15:0]        tolerance_cfg;
    result_t          pending_minima[$];
    int unsigned      error_count;
    int unsigned      searches_run;
    int unsigned      samples_sent;
    int unsigned      cycle_count;
    int unsigned      status_seen [8];

    convex_min_regula_falsi_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint slope_at(longint unsigned i, int unsigned hi);
        if (i >= hi)
            i = hi - 1;
        return curve_store[i + 1] - curve_store[i];
    endfunction

    function automatic status_t locate_minimum(int unsigned n, output longint unsigned idx);
        int unsigned    hi;
        int unsigned    lo;
        longint unsigned low_pos;
        longint unsigned high_pos;
        longint unsigned prev_est;
        longint unsigned span;
        longint unsigned x;
        longint unsigned err;
        longint unsigned mlo;
        longint unsigned mhi;
        longint         dlo;
        longint         dhi;
        longint         dx;
        bit             prev_ok;
        int unsigned    steps;
        idx = 0;
        lo = 0;
        prev_est = 0;
        prev_ok = 1'b0;
        steps = 0;
        if (n < 3)
            return ST_TOO_FEW;
        hi = n - 1;
        if (skip_rising_cfg)
        begin
            while (lo <= hi && slope_at(lo, hi) >= 0)
                lo++;
            if (lo > hi)
                return ST_SKIP_END;
        end
        low_pos = longint'(lo) << FRAC_BITS;
        high_pos = longint'(hi) << FRAC_BITS;
        forever
        begin
            dlo = slope_at(low_pos >> FRAC_BITS, hi);
            dhi = slope_at(high_pos >> FRAC_BITS, hi);
            if ((dlo > 0 && dhi > 0) || (dlo < 0 && dhi < 0))
                return ST_NO_BRACKET;
            if (dlo == dhi)
            begin
                idx = low_pos >> FRAC_BITS;
                return ST_OK;
            end
            span = (high_pos >= low_pos) ? high_pos - low_pos : 0;
            mlo = (dlo < 0) ? -dlo : dlo;
            mhi = (dhi < 0) ? -dhi : dhi;
            x = low_pos + (mlo * span) / (mlo + mhi);
            dx = slope_at(x >> FRAC_BITS, hi);
            if ((dx > 0 && dlo < 0) || (dx < 0 && dlo > 0))
                high_pos = x;
            else
                low_pos = x;
            steps++;
            err = (x >= prev_est) ? x - prev_est : prev_est - x;
            idx = x >> FRAC_BITS;
            if (prev_ok && err < longint'(tolerance_cfg))
                return ST_OK;
            prev_est = x;
            prev_ok = 1'b1;
            if (steps >= MAX_STEPS)
                return ST_STEP_LIMIT;
        end
    endfunction

    function automatic void absorb_sample(item_t it);
        longint unsigned idx;
        result_t         r;
        if (stored_count < DEPTH)
        begin
            curve_store[stored_count] = longint'(it.sample);
            stored_count++;
        end
        if (it.last)
        begin
            r.status = locate_minimum(stored_count, idx);
            r.min_index = idx[9:0];
            stored_count = 0;
            pending_minima = {pending_minima, r};
        end
    endfunction

    task automatic send_sample(logic signed [31:0] value, logic is_last);
        @(negedge clk);
        start = 1'b1;
        item.sample = value;
        item.last = is_last;
        do
            @(posedge clk);
        while (busy);
        absorb_sample(item);
        samples_sent++;
    endtask

    task automatic pause(int unsigned cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    task automatic random_pause();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            pause(0);
        else if (roll < 90)
            pause($urandom_range(3, 1));
        else
            pause($urandom_range(40, 8));
    endtask

    task automatic drain();
        pause(1);
        while (pending_minima.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t index, logic [CFG_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(posedge clk);
        if (index == CFG_SKIP_RISING)
            skip_rising_cfg = value[0];
        else
            tolerance_cfg = value[15:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_curve(longint values[$], bit gaps);
        foreach (values[i])
        begin
            send_sample(values[i][31:0], i == values.size() - 1);
            if (gaps)
                random_pause();
        end
    endtask

    function automatic void make_convex(int unsigned n, int spread, ref longint values[$]);
        int     slopes[$];
        longint y;
        values.delete();
        for (int unsigned i = 0; i + 1 < n; i++)
            slopes = {slopes, int'($signed($urandom_range(2 * spread)) - spread)};
        slopes.sort();
        y = $signed($urandom_range(32'h7fff_ffff)) - 32'sh4000_0000;
        values = {values, y};
        foreach (slopes[i])
        begin
            y += slopes[i];
            values = {values, y};
        end
    endfunction

    task automatic test_edge_cases();
        write_register(CFG_SKIP_RISING, 0);
        send_curve('{32'sh7fff_ffff, -64'sd2147483648, 32'sh7fff_ffff}, 0);
        send_curve('{-64'sd2147483648, 32'sh7fff_ffff, -64'sd2147483648}, 0);
        send_curve('{5}, 0);
        send_curve('{5, -5}, 0);
        send_curve('{7, 7, 7, 7}, 0);
        send_curve('{40, 30, 20, 10}, 0);
        send_curve('{9, 4, 1, 0, 1, 4, 9}, 0);
        write_register(CFG_SKIP_RISING, 1);
        send_curve('{1, 2, 3}, 0);
        send_curve('{1, 3, 2, 1, 0, 2}, 0);
        write_register(CFG_TOLERANCE, 65535);
    endtask

    task automatic test_full_store();
        longint values[$];
        for (int i = 0; i < DEPTH + 6; i++)
            values = {values, longint'((i - 600) * (i - 600))};
        write_register(CFG_SKIP_RISING, 0);
        write_register(CFG_TOLERANCE, 1);
        send_curve(values, 0);
        drain();
    endtask

    task automatic test_random_curves(int unsigned target);
        longint      values[$];
        int unsigned roll;
        int unsigned n;
        while (samples_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
            begin
                write_register(CFG_SKIP_RISING, CFG_W'($urandom_range(1)));
                case ($urandom_range(2))
                    0: write_register(CFG_TOLERANCE, 1);
                    1: write_register(CFG_TOLERANCE, 65535);
                    default: write_register(CFG_TOLERANCE, CFG_W'($urandom_range(65535, 1)));
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 3);
                make_convex(n, (1 << $urandom_range(24, 2)), values);
            end
            else
            begin
                values.delete();
                n = (roll < 82) ? $urandom_range(2, 1) : $urandom_range(12, 3);
                repeat (n)
                    values = {values, longint'($signed($urandom()))};
            end
            send_curve(values, 1);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_minima.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual index %0d status %0d",
                         $time, result.min_index, result.status);
                error_count++;
            end
            else
            begin
                want = pending_minima.pop_front();
                searches_run++;
                status_seen[want.status]++;
                if (result.min_index !== want.min_index)
                begin
                    $display("%0t: min_index mismatch, expected %0d actual %0d",
                             $time, want.min_index, result.min_index);
                    error_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, result.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_minima.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SKIP_RISING;
        cfg_data = '0;
        stored_count = 0;
        skip_rising_cfg = 1'b0;
        tolerance_cfg = 16'd6554;
        error_count = 0;
        searches_run = 0;
        samples_sent = 0;
        cycle_count = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_edge_cases();
        test_full_store();
        test_random_curves(800 + DEPTH);
        drain();
        repeat (SETTLE)
            @(posedge clk);
        if (pending_minima.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_minima.size());
            error_count++;
        end
        $display("Sent %0d samples and checked %0d searches.", samples_sent, searches_run);
        $display("Outcomes ok %0d, too few %0d, skip end %0d, no bracket %0d, step limit %0d.",
                 status_seen[ST_OK], status_seen[ST_TOO_FEW], status_seen[ST_SKIP_END],
                 status_seen[ST_NO_BRACKET], status_seen[ST_STEP_LIMIT]);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### files.f
hw/rtl/cmrf_pkg.sv
hw/rtl/cmrf_ram.sv
hw/rtl/cmrf_ctrl.sv
hw/rtl/cmrf_dp.sv
hw/rtl/convex_min_regula_falsi_search.sv
hw/rtl/cmrf_checker.sv
tb/sv/tb.sv
